// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned PRIO_W       = 8;
	localparam int unsigned COUNT_OUT_W  = 5;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

	// Broadcast to every cell of the chain for the request being applied.
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctrl_t;

endpackage

// ===== rtl/spq_req_if.sv =====
interface spq_req_if import spq_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [VALUE_W-1:0] entry_value;
	logic [PRIO_W-1:0]         entry_priority;

	modport source (output valid, output mode, output entry_value, output entry_priority,
		input ready);
	modport sink (input valid, input mode, input entry_value, input entry_priority,
		output ready);

endinterface

// ===== rtl/spq_rsp_if.sv =====
interface spq_rsp_if import spq_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] head_value;
	logic [PRIO_W-1:0]         head_priority;
	logic                      is_empty;
	logic [COUNT_OUT_W-1:0]    entry_count;
	logic                      overflow;

	modport source (output valid, output head_value, output head_priority, output is_empty,
		output entry_count, output overflow, input ready);
	modport sink (input valid, input head_value, input head_priority, input is_empty,
		input entry_count, input overflow, output ready);

endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the ordered chain. It either holds, takes the new entry,
// takes its left neighbour's entry (insert) or its right neighbour's (remove).
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       left_new_ahead,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output logic       new_ahead,
	output entry_t     entry,
	output entry_t     entry_next
);

	entry_t entry_q;

	// The new entry belongs in front of this slot when the slot is free or
	// holds a strictly lower priority, which keeps equal priorities in order.
	assign new_ahead = !occupied || (entry_q.prio < ctrl.item.prio);
	assign entry     = entry_q;

	always_comb begin
		priority if (ctrl.ins && left_new_ahead) begin
			entry_next = left_entry;
		end else if (ctrl.ins && new_ahead) begin
			entry_next = ctrl.item;
		end else if (ctrl.rem) begin
			entry_next = right_entry;
		end else begin
			entry_next = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_next;
	end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Channel | Dir | Payload                                                  | Handshake
// req     | in  | mode, entry_value, entry_priority                        | valid/ready
// rsp     | out | head_value, head_priority, is_empty, entry_count, overflow | valid/ready
//
// Every cell compares its priority with the new entry and shifts in the same cycle
// as the request is accepted, so the rate is set by that chain step.
// A result is registered in the cycle after its request and stays in the result register
// until taken; a new request is accepted in the same cycle as the result is taken.
// Reset clears only the entry count and the result flag; there is no clearing pass.
// While rsp stalls with a result waiting, req is held off.
module stable_priority_queue import spq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// Chain state. The slots below the count are occupied; the rest hold
	// whatever was last shifted into them and are never shown.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	entry_t     cell_entry [CAPACITY];
	entry_t     cell_next  [CAPACITY];
	logic       cell_new_ahead [CAPACITY];
	logic       occupied [CAPACITY];
	cell_ctrl_t ctrl;

	logic accept;
	logic is_ins;
	logic full;
	logic drop;

	// The result register parts the two channels.
	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_value_q;
	logic [PRIO_W-1:0]         rsp_prio_q;
	logic                      rsp_empty_q;
	logic [COUNT_OUT_W-1:0]    rsp_count_q;
	logic                      rsp_ovf_q;
	logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_ins    = (req.mode == MODE_INSERT);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign drop      = is_ins && full;

	// A remove on an empty queue and an insert into a full one both leave
	// the chain untouched.
	assign ctrl.ins        = accept && is_ins && !full;
	assign ctrl.rem        = accept && (req.mode == MODE_REMOVE) && (count_q != '0);
	assign ctrl.item.value = req.entry_value;
	assign ctrl.item.prio  = req.entry_priority;

	always_comb begin
		priority if (ctrl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_new_ahead;
		entry_t left_entry;
		entry_t right_entry;

		assign occupied[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_new_ahead = 1'b0;
			assign left_entry     = ctrl.item;
		end else begin : g_mid
			assign left_new_ahead = cell_new_ahead[i-1];
			assign left_entry     = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.occupied       (occupied[i]),
			.left_new_ahead (left_new_ahead),
			.left_entry     (left_entry),
			.right_entry    (right_entry),
			.new_ahead      (cell_new_ahead[i]),
			.entry          (cell_entry[i]),
			.entry_next     (cell_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The reported count is the low bits of the true count.
	assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};

	// The head shown is the value slot zero takes at this edge; an empty
	// queue reports zeros.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_empty_q <= (count_next == '0);
			rsp_count_q <= count_wide[COUNT_OUT_W-1:0];
			rsp_ovf_q   <= drop;
			if (count_next == '0) begin
				rsp_value_q <= '0;
				rsp_prio_q  <= '0;
			end else begin
				rsp_value_q <= cell_next[0].value;
				rsp_prio_q  <= cell_next[0].prio;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.head_value    = rsp_value_q;
	assign rsp.head_priority = rsp_prio_q;
	assign rsp.is_empty      = rsp_empty_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.overflow      = rsp_ovf_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_ovf_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drop |=> rsp_ovf_q && (count_q == CNT_W'(CAPACITY)))
		else $error("dropped insert not flagged or count changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_empty_q |-> (rsp_value_q == '0) && (rsp_prio_q == '0))
		else $error("empty result with nonzero head");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request produced no result");
`endif

endmodule
